/* hw/rtl/ic_pkg.sv */
// Package for the inversion counter: sizes, limits and the token that travels
// along the compare chain. Used by ic_cell, ic_tail and inversion_counter.
// No dependencies.
package ic_pkg;

    // Number of elements that one array may store (one compare cell each).
    localparam int MAX_ELEMENTS = 1024;

    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 19;
    localparam int COUNT_W = 11;

    // Index of a stored element, and a counter that can also hold MAX_ELEMENTS.
    localparam int IDX_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Widths for the saturating total and element count.
    localparam int SUM_W  = ((TOTAL_W > IDX_W) ? TOTAL_W : IDX_W) + 1;
    localparam int ECMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TOTAL_W + COUNT_W + 1 + 7) / 8) * 8;

    // One element on its way through the chain.
    typedef struct packed {
        logic                      valid;   // slot holds an element
        logic                      last;    // element ends the array
        logic                      stored;  // element has a cell of its own
        logic [IDX_W-1:0]          idx;     // position within the array
        logic signed [VALUE_W-1:0] key;     // element value
        logic [IDX_W-1:0]          cnt;     // earlier elements greater so far
    } t_token;

endpackage

/* hw/rtl/ic_cell.sv */
// One cell of the compare chain: holds one stored element of the array and
// counts it against every later element that passes. Depends on ic_pkg.
module ic_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [ic_pkg::IDX_W-1:0] i_idx,
    input  ic_pkg::t_token       i_tok,
    output ic_pkg::t_token       o_tok
);
    import ic_pkg::*;

    logic signed [VALUE_W-1:0] r_val;
    t_token                    r_tok;
    t_token                    n_tok;
    logic                      w_hit;
    logic                      w_cmp;

    // The element whose position matches this cell is written here; later
    // elements of the same array compare against it on their way past.
    assign w_hit = i_tok.valid && i_tok.stored && (i_tok.idx == i_idx);
    assign w_cmp = i_tok.valid && i_tok.stored && (i_tok.idx > i_idx);

    always_comb begin
        n_tok = i_tok;
        if (w_cmp && ($signed(r_val) > $signed(i_tok.key))) begin
            n_tok.cnt = i_tok.cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_hit) begin
            r_val <= i_tok.key;
        end
    end

    assign o_tok = r_tok;

endmodule

/* hw/rtl/ic_tail.sv */
// End of the compare chain: running total, element count, overflow flag and
// the result register of the master stream. Depends on ic_pkg.
module ic_tail (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ic_pkg::t_token               i_tok,
    input  logic                         i_m_tready,
    output logic                         o_adv,
    output logic                         o_m_tvalid,
    output logic [ic_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import ic_pkg::*;

    logic [TOTAL_W-1:0] r_total;
    logic [CNT_W-1:0]   r_elems;
    logic               r_ovf;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_res_total;
    logic [COUNT_W-1:0] r_res_count;
    logic               r_res_ovf;

    logic [SUM_W-1:0]   w_sum;
    logic [TOTAL_W-1:0] n_total;
    logic [CNT_W-1:0]   n_elems;
    logic               n_ovf;
    logic [COUNT_W-1:0] w_count_sat;
    logic               w_take;

    // The whole chain moves only when the result register can take a beat.
    assign o_adv  = !r_out_valid || i_m_tready;
    assign w_take = o_adv && i_tok.valid;

    assign w_sum   = SUM_W'(r_total) + SUM_W'(i_tok.cnt);
    assign n_total = (w_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
    assign n_elems = i_tok.stored ? (r_elems + 1'b1) : r_elems;
    assign n_ovf   = r_ovf || !i_tok.stored;

    assign w_count_sat = (ECMP_W'(n_elems) > ECMP_W'(COUNT_MAX)) ?
                         COUNT_MAX : n_elems[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_elems     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result may replace one that leaves on the same edge.
            if (w_take && i_tok.last) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                if (i_tok.last) begin
                    r_total <= '0;
                    r_elems <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_elems <= n_elems;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_tok.last) begin
            r_res_total <= n_total;
            r_res_count <= w_count_sat;
            r_res_ovf   <= n_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_res_ovf, r_res_count, r_res_total});

    // A result appears only after a final element has left the chain.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_tok.valid && i_tok.last && o_adv))
        else $error("result raised without a final element");

    // Within an array the total never falls.
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_tok.last) |=> (r_total >= $past(r_total)))
        else $error("running total decreased inside an array");

    // An element can only have found as many greater ones as precede it.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.valid && i_tok.stored) |-> (i_tok.cnt <= i_tok.idx))
        else $error("count exceeds number of earlier elements");

    // An element beyond capacity is never compared.
    a_overflow_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.valid && !i_tok.stored) |-> (i_tok.cnt == '0))
        else $error("element beyond capacity carries a count");

endmodule

/* hw/rtl/inversion_counter.sv */
// Top level of the inversion counter: element intake, the chain of compare
// cells and the result stage. Depends on ic_pkg, ic_cell and ic_tail.
//
//  Channel | Direction | Ports                               | Beat carries
//  --------+-----------+-------------------------------------+-----------------------------
//  input   | in        | i_s_tvalid o_s_tready i_s_tdata     | one array element, last flag
//          |           | i_s_tlast                           |
//  result  | out       | o_m_tvalid i_m_tready o_m_tdata     | total, count, overflow
//
// An element beat is taken in every cycle in which the result side is not stalled.
// Each element walks the chain of MAX_ELEMENTS cells, one cell a cycle while the result
// side is not stalled, and the result of an array is registered once its final element
// has left the last cell and reached the result stage.
// Reset is synchronous and active low; it clears the chain's valid slots and the
// counters, while the stored elements are left as they are.
// While a result waits unclaimed the whole chain and the input side stand still.
module inversion_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [ic_pkg::S_TDATA_W-1:0] i_s_tdata,   // [31:0] value (signed)
    input  logic                         i_s_tlast,   // last element of the array
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [ic_pkg::M_TDATA_W-1:0] o_m_tdata    // [18:0] inversion_total,
                                                      // [29:19] element_count,
                                                      // [30] overflow, [31] zero
);
    import ic_pkg::*;

    logic             w_adv;
    logic             w_accept;
    logic             w_has_room;
    logic [CNT_W-1:0] r_seen;
    t_token           w_tok [0:MAX_ELEMENTS];

    // Elements are numbered at intake; once MAX_ELEMENTS of the current array
    // have been numbered, later ones travel as unstored and only flag overflow.
    assign w_has_room = (r_seen < CNT_W'(MAX_ELEMENTS));
    assign o_s_tready = w_adv;
    assign w_accept   = i_s_tvalid && w_adv;

    always_comb begin
        w_tok[0].valid  = i_s_tvalid;
        w_tok[0].last   = i_s_tlast;
        w_tok[0].stored = w_has_room;
        w_tok[0].idx    = r_seen[IDX_W-1:0];
        w_tok[0].key    = $signed(i_s_tdata[VALUE_W-1:0]);
        w_tok[0].cnt    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_accept) begin
            if (i_s_tlast) begin
                r_seen <= '0;
            end else if (w_has_room) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    // The chain itself: cell g keeps element g of the current array.
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        ic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_idx   (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Accumulation and the result register; it also decides when the chain moves.
    ic_tail u_tail (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok      (w_tok[MAX_ELEMENTS]),
        .i_m_tready (i_m_tready),
        .o_adv      (w_adv),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* tb/sv/inversion_counter_tb.sv */
// Self-checking testbench for inversion_counter: streams arrays of signed elements,
// predicts each array's inversion total, element count and overflow flag, and checks
// every result beat. Depends on ic_pkg and the inversion_counter RTL only.
`timescale 1ns / 1ps

module inversion_counter_tb;

    import ic_pkg::*;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    // Random elements to stream after the directed and capacity arrays.
    localparam int RANDOM_ITEMS = 510;

    // A result leaves only after its final element has passed the whole chain, a stalled
    // result holds the input side as well, and the closing drain gives the chain one more
    // pass, so many chain lengths of silence mean that the block has hung.
    localparam int QUIET_LIMIT = 8 * (MAX_ELEMENTS + 1) + 400;

    // One result beat as it sits in the low bits of o_m_tdata, lowest field last.
    typedef struct packed {
        logic               overflow;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
    } t_array_summary;

    // Keeps its own copy of the array being counted and a queue of the summaries
    // that the arrays closed so far should produce, oldest first.
    class inversion_scoreboard;
        logic signed [VALUE_W-1:0] kept[$];
        int unsigned               tally;
        bit                        spilled;
        t_array_summary            pending[$];
        int                        failures;

        // An element that finds the array full is neither stored nor compared,
        // but it still marks the array as overflowed and may still close it.
        function void note_element(logic signed [VALUE_W-1:0] value, logic last);
            int unsigned    greater;
            t_array_summary summary;
            if (kept.size() < MAX_ELEMENTS) begin
                greater = 0;
                foreach (kept[i]) begin
                    if (kept[i] > value)
                        greater++;
                end
                tally = tally + greater;
                if (tally > TOTAL_MAX)
                    tally = TOTAL_MAX;
                kept.push_back(value);
            end else begin
                spilled = 1'b1;
            end
            if (last) begin
                summary.total    = tally[TOTAL_W-1:0];
                summary.count    = (kept.size() > COUNT_MAX) ? COUNT_MAX
                                                             : COUNT_W'(kept.size());
                summary.overflow = spilled;
                pending.push_back(summary);
                kept.delete();
                tally   = 0;
                spilled = 1'b0;
            end
        endfunction

        function void check_summary(logic [M_TDATA_W-1:0] beat);
            t_array_summary got;
            t_array_summary want;
            got = beat[TOTAL_W+COUNT_W:0];
            if (pending.size() == 0) begin
                $error("result beat %h arrived with no array outstanding", beat);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.total !== want.total) begin
                $error("inversion_total: expected %0d, got %0d", want.total, got.total);
                failures++;
            end
            if (got.count !== want.count) begin
                $error("element_count: expected %0d, got %0d", want.count, got.count);
                failures++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                failures++;
            end
            if (beat[M_TDATA_W-1:TOTAL_W+COUNT_W+1] !== '0) begin
                $error("padding: expected 0, got %0h", beat[M_TDATA_W-1:TOTAL_W+COUNT_W+1]);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;   // [31:0] value (signed)
    logic                 i_s_tlast  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;         // [18:0] total, [29:19] count, [30] overflow

    inversion_scoreboard sb;

    // While steady is set neither side idles, so the chain sees back-to-back beats.
    bit steady = 1'b0;
    bit moved;
    int quiet_cycles = 0;

    inversion_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Offers one element, idling first now and then, and returns at the edge on
    // which the beat is taken. Nothing here lowers tvalid in the step that the
    // following element raises it, so back-to-back beats stay high throughout.
    task automatic send_element(input logic signed [VALUE_W-1:0] value, input logic last);
        while (!steady && $urandom_range(0, 99) < 10) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // Half of the elements are fully random, the rest crowd around a few values so
    // that equal elements, which must not count as inversions, turn up often.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6, 7:       v = $signed({28'd0, 4'($urandom_range(0, 8))}) - 4;
            8:             v = ($urandom_range(0, 1) != 0) ? VALUE_MIN : VALUE_MAX;
            default:       v = ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
        endcase
        return v;
    endfunction

    // Beats are sampled at the rising edge, before anything driven at that edge takes
    // effect. The same process drives the result side's tready and keeps the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                sb.note_element($signed(i_s_tdata[VALUE_W-1:0]), i_s_tlast);
                moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_summary(o_m_tdata);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("inversion_counter regression: fail");
                $finish;
            end
        end
        i_m_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    initial begin
        int unsigned          len;
        int                   random_sent;
        longint               ramp;
        sb = new;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed arrays. A single element has nothing before it to compare with.
        send_element(VALUE_MIN, 1'b1);
        // The two extremes in both orders: the sign must decide the comparison.
        send_element(VALUE_MAX, 1'b0);
        send_element(VALUE_MIN, 1'b1);
        send_element(VALUE_MIN, 1'b0);
        send_element(VALUE_MAX, 1'b1);
        // Equal elements are not inversions; only the strictly greater zero counts.
        send_element(-32'sd1, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(-32'sd1, 1'b1);
        send_element(32'sd5, 1'b0);
        send_element(32'sd5, 1'b0);
        send_element(32'sd5, 1'b1);
        send_element(VALUE_MAX, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(VALUE_MIN, 1'b1);

        // A full array in strictly falling order gives the largest possible total.
        // Two more elements follow beyond capacity: both are dropped, and the second
        // one, which carries the last flag, still closes the array with the overflow
        // flag set.
        ramp = VALUE_MAX;
        for (int k = 0; k < MAX_ELEMENTS + 2; k++) begin
            send_element(ramp[VALUE_W-1:0], k == MAX_ELEMENTS + 1);
            ramp = ramp - $urandom_range(1, 2_000_000);
        end

        // Random arrays, mostly short, now and then up to 250 elements long,
        // with a stretch in the middle where neither side idles.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            steady = (random_sent >= 150) && (random_sent < 350);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 250)
                                               : $urandom_range(1, 32);
            for (int k = 0; k < len; k++)
                send_element(pick_value(), k == len - 1);
            random_sent += len;
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;

        // Let every result drain, then give the chain one more pass so that a
        // stray beat still has time to show up.
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (MAX_ELEMENTS + 20) @(posedge i_clk);

        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("inversion_counter regression: pass");
        end else begin
            $display("inversion_counter regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ic_pkg.sv
hw/rtl/ic_cell.sv
hw/rtl/ic_tail.sv
hw/rtl/inversion_counter.sv
tb/sv/inversion_counter_tb.sv
